FILE: rtl/random_prim_maze_generator_unit_assert.svh
// Assertion macros shared by the maze generator RTL.
`ifndef RANDOM_PRIM_MAZE_GENERATOR_UNIT_ASSERT_SVH
`define RANDOM_PRIM_MAZE_GENERATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define RPMG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RPMG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPMG_ASSERT(lbl, clk, rst, prop, msg)
`define RPMG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/rpmg_pkg.sv
package rpmg_pkg;

   localparam int MAP_WIDTH      = 31;
   localparam int MAP_HEIGHT     = 31;
   localparam int LIST_DEPTH_DEF = 1024;
   localparam int MAP_CELLS      = 1024;
   localparam int MAP_AW         = 10;
   localparam int X_MOD          = MAP_WIDTH / 2 - 1;
   localparam int Y_MOD          = MAP_HEIGHT / 2 - 1;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STEP  = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] rand_a;
      logic [15:0] rand_b;
      logic [4:0]  cell_x;
      logic [4:0]  cell_y;
   } req_type;

   typedef struct packed {
      logic        carved;
      logic [4:0]  wall_x;
      logic [4:0]  wall_y;
      logic        done_res;
      logic        cell_open;
      logic [10:0] list_count;
      logic        overflow;
   } rsp_type;

   // Initial wall pattern: odd interior cells are open, everything else is wall.
   function automatic logic wall_pattern(input logic [4:0] x, input logic [4:0] y);
      logic in_grid;
      in_grid = (32'(x) < MAP_WIDTH) && (32'(y) < MAP_HEIGHT);
      return in_grid && x[0] && y[0] && (32'(x) != MAP_WIDTH - 1) &&
             (32'(y) != MAP_HEIGHT - 1);
   endfunction

endpackage

FILE: rtl/rpmg_ram.sv
module rpmg_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/random_prim_maze_generator_unit.sv
// Start: rewrites both maps, picks the start cell by two divisions, then pushes its walls.
// Step: a pass of the shared remainder unit, a walk over the wall list,
// then the cell checks and up to four neighbor pushes.
// One item is worked at a time.
// After reset a clearing pass zeroes both maps; no item is taken meanwhile.
`include "random_prim_maze_generator_unit_assert.svh"

module random_prim_maze_generator_unit
   import rpmg_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int AW = $clog2(LIST_DEPTH);

   typedef enum logic [16:0] {
      S_CLEAR    = 17'h00001,
      S_IDLE     = 17'h00002,
      S_SWEEP    = 17'h00004,
      S_DIV      = 17'h00008,
      S_SETSTART = 17'h00010,
      S_PICKRD   = 17'h00020,
      S_PICKWT   = 17'h00040,
      S_SCAN     = 17'h00080,
      S_CELLA_RD = 17'h00100,
      S_CELLA_WT = 17'h00200,
      S_CELLB_RD = 17'h00400,
      S_CELLB_WT = 17'h00800,
      S_OPEN     = 17'h01000,
      S_NB_RD    = 17'h02000,
      S_NB_WT    = 17'h04000,
      S_READ_WT  = 17'h08000,
      S_RESP     = 17'h10000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [15:0]   rb_ff, rb_in;
   logic          in_grid_ff, in_grid_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          carved_ff, carved_in;
   logic [4:0]    wx_ff, wx_in, wy_ff, wy_in;
   logic          open_ff, open_in;
   logic [4:0]    tx_ff, tx_in, ty_ff, ty_in;
   logic [4:0]    sx_ff, sx_in;
   logic          have_ff, have_in;
   logic [CW:0]   rem_ff, rem_in;
   logic [15:0]   dvd_ff, dvd_in;
   logic [CW-1:0] dsr_ff, dsr_in;
   logic [3:0]    dcnt_ff, dcnt_in;
   logic          phase_ff, phase_in;
   logic [AW-1:0] r_ff, r_in;
   logic [9:0]    pick_ff, pick_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;
   logic [9:0]    sweep_ff, sweep_in;
   logic [1:0]    nb_ff, nb_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic              maze_we, maze_re, maze_wd, maze_rd;
   logic [MAP_AW-1:0] maze_wa, maze_ra;
   logic              vis_we, vis_re, vis_wd, vis_rd;
   logic [MAP_AW-1:0] vis_wa, vis_ra;
   logic              list_we, list_re;
   logic [AW-1:0]     list_wa, list_ra;
   logic [9:0]        list_wd, list_rd;

   logic [CW:0]   rem_shift, rem_next;
   logic [4:0]    ax, ay, bx, by, nx, ny;
   logic          nb_ok;

   rpmg_ram #(.WIDTH(1), .DEPTH(MAP_CELLS)) u_maze (
      .clock(clock), .wr_en(maze_we), .wr_addr(maze_wa), .wr_data(maze_wd),
      .rd_en(maze_re), .rd_addr(maze_ra), .rd_data(maze_rd)
   );

   rpmg_ram #(.WIDTH(1), .DEPTH(MAP_CELLS)) u_visited (
      .clock(clock), .wr_en(vis_we), .wr_addr(vis_wa), .wr_data(vis_wd),
      .rd_en(vis_re), .rd_addr(vis_ra), .rd_data(vis_rd)
   );

   rpmg_ram #(.WIDTH(10), .DEPTH(LIST_DEPTH)) u_list (
      .clock(clock), .wr_en(list_we), .wr_addr(list_wa), .wr_data(list_wd),
      .rd_en(list_re), .rd_addr(list_ra), .rd_data(list_rd)
   );

   // One restoring remainder step per cycle; the remainder stays below the divisor.
   always_comb begin
      rem_shift = {rem_ff[CW-1:0], dvd_ff[15]};
      if (rem_shift >= {1'b0, dsr_ff}) begin
         rem_next = rem_shift - {1'b0, dsr_ff};
      end else begin
         rem_next = rem_shift;
      end
   end

   // The two cells on either side of the wall being taken.
   always_comb begin
      if (!wx_ff[0]) begin
         ax = wx_ff - 5'd1;
         ay = wy_ff;
         bx = wx_ff + 5'd1;
         by = wy_ff;
      end else begin
         ax = wx_ff;
         ay = wy_ff - 5'd1;
         bx = wx_ff;
         by = wy_ff + 5'd1;
      end
   end

   always_comb begin
      nx    = tx_ff;
      ny    = ty_ff;
      nb_ok = 1'b0;
      case (nb_ff)
         2'd0: begin
            nx    = tx_ff - 5'd1;
            nb_ok = tx_ff >= 5'd2;
         end
         2'd1: begin
            nx    = tx_ff + 5'd1;
            nb_ok = (32'(tx_ff) + 1) < (MAP_WIDTH - 1);
         end
         2'd2: begin
            ny    = ty_ff - 5'd1;
            nb_ok = ty_ff >= 5'd2;
         end
         default: begin
            ny    = ty_ff + 5'd1;
            nb_ok = (32'(ty_ff) + 1) < (MAP_HEIGHT - 1);
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      rb_in      = rb_ff;
      in_grid_in = in_grid_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      carved_in  = carved_ff;
      wx_in      = wx_ff;
      wy_in      = wy_ff;
      open_in    = open_ff;
      tx_in      = tx_ff;
      ty_in      = ty_ff;
      sx_in      = sx_ff;
      have_in    = have_ff;
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      dsr_in     = dsr_ff;
      dcnt_in    = dcnt_ff;
      phase_in   = phase_ff;
      r_in       = r_ff;
      pick_in    = pick_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      sweep_in   = sweep_ff;
      nb_in      = nb_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;

      maze_we = 1'b0;
      maze_wa = '0;
      maze_wd = 1'b0;
      maze_re = 1'b0;
      maze_ra = '0;
      vis_we  = 1'b0;
      vis_wa  = '0;
      vis_wd  = 1'b0;
      vis_re  = 1'b0;
      vis_ra  = '0;
      list_we = 1'b0;
      list_wa = '0;
      list_wd = '0;
      list_re = 1'b0;
      list_ra = '0;

      unique case (state_ff)
         S_CLEAR: begin
            maze_we = 1'b1;
            maze_wa = sweep_ff;
            vis_we  = 1'b1;
            vis_wa  = sweep_ff;
            if (&sweep_ff) begin
               state_in = S_IDLE;
            end
            sweep_in = sweep_ff + 10'd1;
         end
         S_IDLE: begin
            maze_re = 1'b1;
            maze_ra = {req_data.cell_y, req_data.cell_x};
            if (req_valid) begin
               op_in      = req_data.op;
               rb_in      = req_data.rand_b;
               in_grid_in = (32'(req_data.cell_x) < MAP_WIDTH) &&
                            (32'(req_data.cell_y) < MAP_HEIGHT);
               carved_in  = 1'b0;
               wx_in      = '0;
               wy_in      = '0;
               open_in    = 1'b0;
               have_in    = 1'b0;
               rem_in     = '0;
               dvd_in     = req_data.rand_a;
               dcnt_in    = '0;
               phase_in   = 1'b0;
               case (op_type'(req_data.op))
                  OP_START: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                     sweep_in = '0;
                     dsr_in   = CW'(X_MOD);
                     state_in = S_SWEEP;
                  end
                  OP_STEP: begin
                     dsr_in   = count_ff;
                     state_in = (count_ff == '0) ? S_RESP : S_DIV;
                  end
                  OP_READ: begin
                     state_in = S_READ_WT;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            maze_we = 1'b1;
            maze_wa = sweep_ff;
            maze_wd = wall_pattern(sweep_ff[4:0], sweep_ff[9:5]);
            vis_we  = 1'b1;
            vis_wa  = sweep_ff;
            if (&sweep_ff) begin
               state_in = S_DIV;
            end
            sweep_in = sweep_ff + 10'd1;
         end
         S_DIV: begin
            rem_in  = rem_next;
            dvd_in  = {dvd_ff[14:0], 1'b0};
            dcnt_in = dcnt_ff + 4'd1;
            if (&dcnt_ff) begin
               if (op_type'(op_ff) == OP_STEP) begin
                  r_in     = AW'(rem_next);
                  state_in = S_PICKRD;
               end else if (!phase_ff) begin
                  sx_in    = {rem_next[3:0], 1'b1};
                  rem_in   = '0;
                  dvd_in   = rb_ff;
                  dsr_in   = CW'(Y_MOD);
                  phase_in = 1'b1;
               end else begin
                  tx_in    = sx_ff;
                  ty_in    = {rem_next[3:0], 1'b1};
                  state_in = S_SETSTART;
               end
            end
         end
         S_SETSTART: begin
            vis_we   = 1'b1;
            vis_wa   = {ty_ff, tx_ff};
            vis_wd   = 1'b1;
            nb_in    = '0;
            state_in = S_NB_RD;
         end
         S_PICKRD: begin
            list_re  = 1'b1;
            list_ra  = r_ff;
            state_in = S_PICKWT;
         end
         S_PICKWT: begin
            pick_in  = list_rd;
            wx_in    = list_rd[4:0];
            wy_in    = list_rd[9:5];
            idx_in   = '0;
            found_in = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // Reads run one entry ahead; after the first match each entry moves down one.
            if (idx_ff < count_ff) begin
               list_re = 1'b1;
               list_ra = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
            end
            if (idx_ff != '0) begin
               if (found_ff) begin
                  list_we = 1'b1;
                  list_wa = AW'(idx_ff - CW'(2));
                  list_wd = list_rd;
               end else if (list_rd == pick_ff) begin
                  found_in = 1'b1;
               end
            end
            if (idx_ff == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_CELLA_RD;
            end
         end
         S_CELLA_RD: begin
            vis_re   = 1'b1;
            vis_ra   = {ay, ax};
            state_in = S_CELLA_WT;
         end
         S_CELLA_WT: begin
            if (!vis_rd) begin
               vis_we  = 1'b1;
               vis_wa  = {ay, ax};
               vis_wd  = 1'b1;
               have_in = 1'b1;
               tx_in   = ax;
               ty_in   = ay;
            end
            state_in = S_CELLB_RD;
         end
         S_CELLB_RD: begin
            vis_re   = 1'b1;
            vis_ra   = {by, bx};
            state_in = S_CELLB_WT;
         end
         S_CELLB_WT: begin
            if (!vis_rd) begin
               vis_we  = 1'b1;
               vis_wa  = {by, bx};
               vis_wd  = 1'b1;
               have_in = 1'b1;
               tx_in   = bx;
               ty_in   = by;
            end
            state_in = S_OPEN;
         end
         S_OPEN: begin
            if (have_ff && (tx_ff != '0) && (ty_ff != '0)) begin
               maze_we   = 1'b1;
               maze_wa   = {wy_ff, wx_ff};
               maze_wd   = 1'b1;
               carved_in = 1'b1;
               nb_in     = '0;
               state_in  = S_NB_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_NB_RD: begin
            if (nb_ok) begin
               maze_re  = 1'b1;
               maze_ra  = {ny, nx};
               state_in = S_NB_WT;
            end else if (nb_ff == 2'd3) begin
               state_in = S_RESP;
            end else begin
               nb_in = nb_ff + 2'd1;
            end
         end
         S_NB_WT: begin
            if (!maze_rd) begin
               if (count_ff < CW'(LIST_DEPTH)) begin
                  list_we  = 1'b1;
                  list_wa  = AW'(count_ff);
                  list_wd  = {ny, nx};
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            nb_in    = nb_ff + 2'd1;
            state_in = (nb_ff == 2'd3) ? S_RESP : S_NB_RD;
         end
         S_READ_WT: begin
            open_in  = in_grid_ff & maze_rd;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.carved     = carved_ff;
               rsp_data_in.wall_x     = wx_ff;
               rsp_data_in.wall_y     = wy_ff;
               rsp_data_in.done_res   = count_ff == '0;
               rsp_data_in.cell_open  = open_ff;
               rsp_data_in.list_count = 11'(count_ff);
               rsp_data_in.overflow   = ovf_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rb_ff       <= rb_in;
      in_grid_ff  <= in_grid_in;
      carved_ff   <= carved_in;
      wx_ff       <= wx_in;
      wy_ff       <= wy_in;
      open_ff     <= open_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      sx_ff       <= sx_in;
      have_ff     <= have_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      dsr_ff      <= dsr_in;
      dcnt_ff     <= dcnt_in;
      phase_ff    <= phase_in;
      r_ff        <= r_in;
      pick_ff     <= pick_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      nb_ff       <= nb_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RPMG_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(LIST_DEPTH), "list count over depth")
   `RPMG_ASSERT(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP), "result without response state")
   `RPMG_ASSERT(a_list_write_state, clock, reset, list_we |-> (state_ff == S_SCAN || state_ff == S_NB_WT), "list written outside scan or push")
   `RPMG_ASSERT_ALWAYS(a_state_onehot, clock, reset || $onehot(state_ff), "state not one-hot")

endmodule
